/* rtl/tlec_pkg.sv */
// Shared types, constants and helpers for the two-level exclusive cache model.
`timescale 1ns / 1ps
package tlec_pkg;

  localparam int ADDR_W  = 48;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int SET_W   = 12;
  localparam int WAYS_W  = 5;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 4;

  localparam int DEF_L1_SETS  = 64;
  localparam int DEF_L1_WAYS  = 4;
  localparam int DEF_L2_SETS  = 256;
  localparam int DEF_L2_WAYS  = 8;
  localparam int DEF_ADDR_BITS = 48;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_L1_SET_BITS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_L1_WAYS     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_L2_SET_BITS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_L2_WAYS     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_BITS  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_L1_POLICY   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_L2_POLICY   = 3'd6;

  // Access outcome codes
  localparam logic [1:0] OUT_L1_HIT = 2'd0;
  localparam logic [1:0] OUT_L2_HIT = 2'd1;
  localparam logic [1:0] OUT_MISS   = 2'd2;

  // One classified access, front to back
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [SET_W-1:0]  set1;
    logic [SET_W-1:0]  set2;
  } req_t;

  // Effective settings after range fitting
  typedef struct packed {
    logic [3:0]        bb;
    logic [WAYS_W-1:0] w1;
    logic [WAYS_W-1:0] w2;
    logic              l1_lru;
    logic [ADDR_W-1:0] hmask1;
    logic [ADDR_W-1:0] hmask2;
    logic [SET_W-1:0]  smask2;
  } cfg_eff_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

/* rtl/tlec_front.sv */
// Front end: configuration registers, settings fitting and access classification.
`timescale 1ns / 1ps
module tlec_front #(
  parameter int L1_SETS   = tlec_pkg::DEF_L1_SETS,
  parameter int L1_WAYS   = tlec_pkg::DEF_L1_WAYS,
  parameter int L2_SETS   = tlec_pkg::DEF_L2_SETS,
  parameter int L2_WAYS   = tlec_pkg::DEF_L2_WAYS,
  parameter int ADDR_BITS = tlec_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [tlec_pkg::ADDR_W-1:0]         in_address,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlec_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [tlec_pkg::REG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  input  logic                                clearing,
  output logic                                push,
  output tlec_pkg::req_t                      push_req,
  output tlec_pkg::cfg_eff_t                  cfg_eff
);

  localparam int L1_SB_MAX = $clog2(L1_SETS + 1) - 1;
  localparam int L2_SB_MAX = $clog2(L2_SETS + 1) - 1;
  localparam logic [tlec_pkg::ADDR_W-1:0] AMASK = (ADDR_BITS >= tlec_pkg::ADDR_W) ?
      {tlec_pkg::ADDR_W{1'b1}} :
      (({{(tlec_pkg::ADDR_W-1){1'b0}}, 1'b1} << ADDR_BITS) - 1'b1);

  logic [2:0] l1_set_bits_r;
  logic [2:0] l1_ways_r;
  logic [3:0] l2_set_bits_r;
  logic [3:0] l2_ways_r;
  logic [3:0] block_bits_r;
  logic       l1_policy_r;
  logic       l2_policy_r;

  logic [3:0] sb1, sb2;
  logic [4:0] sh1, sh2;
  logic [tlec_pkg::ADDR_W-1:0] a, line;
  logic [tlec_pkg::SET_W-1:0]  smask1, smask2;

  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_set_bits_r <= 3'd6;
      l1_ways_r     <= 3'd4;
      l2_set_bits_r <= 4'd8;
      l2_ways_r     <= 4'd8;
      block_bits_r  <= 4'd6;
      l1_policy_r   <= 1'b0;
      l2_policy_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlec_pkg::REG_L1_SET_BITS: l1_set_bits_r <= cfg_data[2:0];
        tlec_pkg::REG_L1_WAYS:     l1_ways_r     <= cfg_data[2:0];
        tlec_pkg::REG_L2_SET_BITS: l2_set_bits_r <= cfg_data;
        tlec_pkg::REG_L2_WAYS:     l2_ways_r     <= cfg_data;
        tlec_pkg::REG_BLOCK_BITS:  block_bits_r  <= cfg_data;
        tlec_pkg::REG_L1_POLICY:   l1_policy_r   <= cfg_data[0];
        tlec_pkg::REG_L2_POLICY:   l2_policy_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Fit settings to the stores
  always_comb begin
    sb1 = ({1'b0, l1_set_bits_r} > 4'(L1_SB_MAX)) ? 4'(L1_SB_MAX) : {1'b0, l1_set_bits_r};
    sb2 = (l2_set_bits_r > 4'(L2_SB_MAX)) ? 4'(L2_SB_MAX) : l2_set_bits_r;
    sh1 = {1'b0, block_bits_r} + {1'b0, sb1};
    sh2 = {1'b0, block_bits_r} + {1'b0, sb2};
    smask1 = (tlec_pkg::SET_W'(1) << sb1) - tlec_pkg::SET_W'(1);
    smask2 = (tlec_pkg::SET_W'(1) << sb2) - tlec_pkg::SET_W'(1);

    cfg_eff.bb = block_bits_r;
    if (l1_ways_r == 3'd0) cfg_eff.w1 = 5'd1;
    else if ({2'b0, l1_ways_r} > 5'(L1_WAYS)) cfg_eff.w1 = 5'(L1_WAYS);
    else cfg_eff.w1 = {2'b0, l1_ways_r};
    if (l2_ways_r == 4'd0) cfg_eff.w2 = 5'd1;
    else if ({1'b0, l2_ways_r} > 5'(L2_WAYS)) cfg_eff.w2 = 5'(L2_WAYS);
    else cfg_eff.w2 = {1'b0, l2_ways_r};
    // L2 lines are never refreshed, so its policy does not change eviction
    cfg_eff.l1_lru = l1_policy_r | (l2_policy_r & 1'b0);
    cfg_eff.hmask1 = {tlec_pkg::ADDR_W{1'b1}} << sh1;
    cfg_eff.hmask2 = {tlec_pkg::ADDR_W{1'b1}} << sh2;
    cfg_eff.smask2 = smask2;
  end

  // Classify the incoming access
  always_comb begin
    a    = in_address & AMASK;
    line = a >> block_bits_r;
    push_req.op   = in_op;
    push_req.addr = a;
    push_req.set1 = line[tlec_pkg::SET_W-1:0] & smask1;
    push_req.set2 = line[tlec_pkg::SET_W-1:0] & smask2;
  end

  assign busy = q_full | clearing;
  assign push = start & ~busy;

endmodule

/* rtl/tlec_queue.sv */
// Two-entry queue of classified accesses between front and back.
`timescale 1ns / 1ps
module tlec_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlec_pkg::req_t push_req,
  input  logic           pop,
  output tlec_pkg::req_t head,
  output logic           full,
  output logic           empty
);

  tlec_pkg::req_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_req;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head  = ent_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

/* rtl/tlec_back.sv */
// Back end: tag stores, hit and victim decisions, spill to L2, event totals.
`timescale 1ns / 1ps
module tlec_back #(
  parameter int L1_SETS = tlec_pkg::DEF_L1_SETS,
  parameter int L1_WAYS = tlec_pkg::DEF_L1_WAYS,
  parameter int L2_SETS = tlec_pkg::DEF_L2_SETS,
  parameter int L2_WAYS = tlec_pkg::DEF_L2_WAYS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlec_pkg::cfg_eff_t                 cfg_eff,
  input  tlec_pkg::req_t                     head,
  input  logic                               empty,
  output logic                               pop,
  output logic                               clearing,
  output logic                               out_valid,
  output logic [1:0]                         out_outcome,
  output logic                               out_victim_spilled,
  output logic [tlec_pkg::CNT_W-1:0]         out_mem_read_total,
  output logic [tlec_pkg::CNT_W-1:0]         out_mem_write_total,
  output logic [tlec_pkg::CNT_W-1:0]         out_l1_hit_total,
  output logic [tlec_pkg::CNT_W-1:0]         out_l1_miss_total,
  output logic [tlec_pkg::CNT_W-1:0]         out_l2_hit_total
);

  localparam int AW  = tlec_pkg::ADDR_W;
  localparam int SW  = tlec_pkg::STAMP_W;
  localparam int CW  = tlec_pkg::CNT_W;
  localparam int I1W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int I2W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int W1W = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int W2W = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_SPRD  = 6'b010000,
    ST_SPWR  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // L1 store: valid in flops, lines and stamps in memory
  logic [L1_WAYS-1:0]         l1_valid_r [L1_SETS];
  logic [L1_WAYS-1:0][AW-1:0] l1_addr_mem [L1_SETS];
  logic [L1_WAYS-1:0][SW-1:0] l1_fill_mem [L1_SETS];
  logic [L1_WAYS-1:0][SW-1:0] l1_use_mem  [L1_SETS];
  logic [L1_WAYS-1:0][AW-1:0] l1_addr_q;
  logic [L1_WAYS-1:0][SW-1:0] l1_fill_q, l1_use_q;

  // L2 store: everything in memory, cleared by a sweep after reset
  logic [L2_WAYS-1:0]         l2_valid_mem [L2_SETS];
  logic [L2_WAYS-1:0][AW-1:0] l2_addr_mem  [L2_SETS];
  logic [L2_WAYS-1:0][SW-1:0] l2_stamp_mem [L2_SETS];
  logic [L2_WAYS-1:0]         l2_valid_q;
  logic [L2_WAYS-1:0][AW-1:0] l2_addr_q;
  logic [L2_WAYS-1:0][SW-1:0] l2_stamp_q;

  tlec_pkg::req_t cur_r;
  logic [SW-1:0]  stamp_r, stamp_nxt;
  logic [CW-1:0]  rd_tot_r, wr_tot_r, h1_tot_r, m1_tot_r, h2_tot_r;
  logic [AW-1:0]  va_r;
  logic [I2W-1:0] vs2_r;
  logic [SW-1:0]  sp_stamp_r;
  logic [I2W-1:0] clr_r;
  logic           out_valid_r;
  logic [1:0]     out_outcome_r;
  logic           out_spilled_r;

  logic [I1W-1:0] s1;
  logic [I2W-1:0] s2;
  logic [L1_WAYS-1:0] v1;

  // Evaluation results
  logic           h1_found, h2_found, full;
  logic [W1W-1:0] h1_idx, vw;
  logic [W2W-1:0] h2_idx, pw;
  logic [SW-1:0]  best1, st1, best2;
  logic [AW-1:0]  va;
  logic [AW-1:0]  vline;

  // Store write controls
  logic                       l1_we;
  logic [L1_WAYS-1:0]         l1_v_n;
  logic [L1_WAYS-1:0][AW-1:0] l1_addr_n;
  logic [L1_WAYS-1:0][SW-1:0] l1_fill_n, l1_use_n;
  logic                       l2_we;
  logic [I2W-1:0]             l2_wa, l2_ra;
  logic [L2_WAYS-1:0]         l2_v_n;
  logic [L2_WAYS-1:0][AW-1:0] l2_addr_n;
  logic [L2_WAYS-1:0][SW-1:0] l2_stamp_n;

  assign s1 = cur_r.set1[I1W-1:0];
  assign s2 = cur_r.set2[I2W-1:0];
  assign v1 = l1_valid_r[s1];

  // Find L1 hit, L1 victim and L2 hit
  always_comb begin
    h1_found = 1'b0;
    h1_idx   = '0;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (!h1_found && (w < int'(cfg_eff.w1)) && v1[w] &&
          (((l1_addr_q[w] ^ cur_r.addr) & cfg_eff.hmask1) == '0)) begin
        h1_found = 1'b1;
        h1_idx   = W1W'(w);
      end
    end
    full = 1'b1;
    vw   = '0;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (full && (w < int'(cfg_eff.w1)) && !v1[w]) begin
        full = 1'b0;
        vw   = W1W'(w);
      end
    end
    best1 = '0;
    if (full) begin
      for (int w = 0; w < L1_WAYS; w++) begin
        st1 = cfg_eff.l1_lru ? l1_use_q[w] : l1_fill_q[w];
        if ((w < int'(cfg_eff.w1)) && (w == 0 || st1 < best1)) begin
          best1 = st1;
          vw    = W1W'(w);
        end
      end
    end
    st1 = '0;
    h2_found = 1'b0;
    h2_idx   = '0;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (!h2_found && (w < int'(cfg_eff.w2)) && l2_valid_q[w] &&
          (((l2_addr_q[w] ^ cur_r.addr) & cfg_eff.hmask2) == '0)) begin
        h2_found = 1'b1;
        h2_idx   = W2W'(w);
      end
    end
    va    = l1_addr_q[vw];
    vline = va >> cfg_eff.bb;
  end

  // Pick the L2 way for a spilled line
  always_comb begin
    logic found;
    found = 1'b0;
    pw    = '0;
    best2 = '0;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (!found && (w < int'(cfg_eff.w2)) && !l2_valid_q[w]) begin
        found = 1'b1;
        pw    = W2W'(w);
      end
    end
    if (!found) begin
      for (int w = 0; w < L2_WAYS; w++) begin
        if ((w < int'(cfg_eff.w2)) && (w == 0 || l2_stamp_q[w] < best2)) begin
          best2 = l2_stamp_q[w];
          pw    = W2W'(w);
        end
      end
    end
  end

  // Build store writes and the next stamp
  always_comb begin
    l1_we      = 1'b0;
    l1_v_n     = v1;
    l1_addr_n  = l1_addr_q;
    l1_fill_n  = l1_fill_q;
    l1_use_n   = l1_use_q;
    l2_we      = 1'b0;
    l2_wa      = s2;
    l2_v_n     = l2_valid_q;
    l2_addr_n  = l2_addr_q;
    l2_stamp_n = l2_stamp_q;
    stamp_nxt  = stamp_r;
    l2_ra      = (state_r == ST_SPRD) ? vs2_r : s2;
    unique case (state_r)
      ST_CLEAR: begin
        l2_we  = 1'b1;
        l2_wa  = clr_r;
        l2_v_n = '0;
      end
      ST_EVAL: begin
        l1_we = 1'b1;
        if (h1_found) begin
          l1_use_n[h1_idx] = stamp_r + SW'(1);
          stamp_nxt        = stamp_r + SW'(1);
        end else if (h2_found) begin
          l2_we          = 1'b1;
          l2_v_n[h2_idx] = 1'b0;
          l1_v_n[vw]     = 1'b1;
          l1_addr_n[vw]  = cur_r.addr;
          if (full) begin
            l1_fill_n[vw] = stamp_r + SW'(3);
            l1_use_n[vw]  = stamp_r + SW'(3);
            stamp_nxt     = stamp_r + SW'(3);
          end else begin
            l1_fill_n[vw] = stamp_r + SW'(1);
            l1_use_n[vw]  = stamp_r + SW'(1);
            stamp_nxt     = stamp_r + SW'(2);
          end
        end else begin
          l1_v_n[vw]    = 1'b1;
          l1_addr_n[vw] = cur_r.addr;
          if (full) begin
            l1_fill_n[vw] = stamp_r + SW'(2);
            l1_use_n[vw]  = stamp_r + SW'(2);
            stamp_nxt     = stamp_r + SW'(2);
          end else begin
            l1_fill_n[vw] = stamp_r + SW'(1);
            l1_use_n[vw]  = stamp_r + SW'(1);
            stamp_nxt     = stamp_r + SW'(1);
          end
        end
      end
      ST_SPWR: begin
        l2_we          = 1'b1;
        l2_wa          = vs2_r;
        l2_v_n[pw]     = 1'b1;
        l2_addr_n[pw]  = va_r;
        l2_stamp_n[pw] = sp_stamp_r;
      end
      default: ;
    endcase
  end

  // L1 line and stamp memory
  always_ff @(posedge clk) begin
    if (l1_we) begin
      l1_addr_mem[s1] <= l1_addr_n;
      l1_fill_mem[s1] <= l1_fill_n;
      l1_use_mem[s1]  <= l1_use_n;
    end
    l1_addr_q <= l1_addr_mem[s1];
    l1_fill_q <= l1_fill_mem[s1];
    l1_use_q  <= l1_use_mem[s1];
  end

  // L1 valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L1_SETS; i++) l1_valid_r[i] <= '0;
    end else if (l1_we) begin
      l1_valid_r[s1] <= l1_v_n;
    end
  end

  // L2 memory
  always_ff @(posedge clk) begin
    if (l2_we) begin
      l2_valid_mem[l2_wa] <= l2_v_n;
      l2_addr_mem[l2_wa]  <= l2_addr_n;
      l2_stamp_mem[l2_wa] <= l2_stamp_n;
    end
    l2_valid_q <= l2_valid_mem[l2_ra];
    l2_addr_q  <= l2_addr_mem[l2_ra];
    l2_stamp_q <= l2_stamp_mem[l2_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == I2W'(L2_SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (!empty) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = (!h1_found && full) ? ST_SPRD : ST_IDLE;
      ST_SPRD:  state_nxt = ST_SPWR;
      ST_SPWR:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign pop      = (state_r == ST_IDLE) && !empty;
  assign clearing = (state_r == ST_CLEAR);

  // Control state, stamp, totals and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      stamp_r     <= '0;
      rd_tot_r    <= '0;
      wr_tot_r    <= '0;
      h1_tot_r    <= '0;
      m1_tot_r    <= '0;
      h2_tot_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= 1'b0;
      if (state_r == ST_CLEAR) clr_r <= clr_r + I2W'(1);
      if (state_r == ST_EVAL) begin
        if (cur_r.op) wr_tot_r <= tlec_pkg::sat_inc(wr_tot_r);
        if (h1_found) begin
          h1_tot_r <= tlec_pkg::sat_inc(h1_tot_r);
        end else begin
          m1_tot_r <= tlec_pkg::sat_inc(m1_tot_r);
          if (h2_found) h2_tot_r <= tlec_pkg::sat_inc(h2_tot_r);
          else rd_tot_r <= tlec_pkg::sat_inc(rd_tot_r);
        end
        if (h1_found || !full) out_valid_r <= 1'b1;
      end
      if (state_r == ST_SPWR) out_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
    if (state_r == ST_EVAL) begin
      out_outcome_r <= h1_found ? tlec_pkg::OUT_L1_HIT :
                       (h2_found ? tlec_pkg::OUT_L2_HIT : tlec_pkg::OUT_MISS);
      out_spilled_r <= !h1_found && full;
      va_r          <= va;
      vs2_r         <= I2W'(vline[tlec_pkg::SET_W-1:0] & cfg_eff.smask2);
      sp_stamp_r    <= h2_found ? stamp_r + SW'(2) : stamp_r + SW'(1);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_victim_spilled  = out_spilled_r;
  assign out_mem_read_total  = rd_tot_r;
  assign out_mem_write_total = wr_tot_r;
  assign out_l1_hit_total    = h1_tot_r;
  assign out_l1_miss_total   = m1_tot_r;
  assign out_l2_hit_total    = h2_tot_r;

endmodule

/* rtl/two_level_exclusive_cache_model.sv */
// Top level of the two-level exclusive cache model: front, queue and back.
//
// Each access passes through the back end as queue pop, store read, then decide
// and write. When an L1 victim is spilled, the spill then reads and rewrites its
// L2 set in the L2 memory, which has one read and one write port. One result per
// access comes out with out_valid for one cycle; the receiver cannot stall it.
// The front holds up to two accesses while the back works. After reset the
// L2 store is swept clear, one set a cycle, with busy high throughout; configuration
// writes are taken during that time.
`timescale 1ns / 1ps
module two_level_exclusive_cache_model #(
  parameter int L1_SETS   = tlec_pkg::DEF_L1_SETS,
  parameter int L1_WAYS   = tlec_pkg::DEF_L1_WAYS,
  parameter int L2_SETS   = tlec_pkg::DEF_L2_SETS,
  parameter int L2_WAYS   = tlec_pkg::DEF_L2_WAYS,
  parameter int ADDR_BITS = tlec_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_op,
  input  logic [tlec_pkg::ADDR_W-1:0]     in_address,
  output logic                            out_valid,
  output logic [1:0]                      out_outcome,
  output logic                            out_victim_spilled,
  output logic [tlec_pkg::CNT_W-1:0]      out_mem_read_total,
  output logic [tlec_pkg::CNT_W-1:0]      out_mem_write_total,
  output logic [tlec_pkg::CNT_W-1:0]      out_l1_hit_total,
  output logic [tlec_pkg::CNT_W-1:0]      out_l1_miss_total,
  output logic [tlec_pkg::CNT_W-1:0]      out_l2_hit_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlec_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tlec_pkg::REG_DATA_W-1:0] cfg_data
);

  tlec_pkg::req_t     push_req, head;
  tlec_pkg::cfg_eff_t cfg_eff;
  logic push, pop, q_full, q_empty, clearing;

  tlec_front #(
    .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L2_SETS(L2_SETS),
    .L2_WAYS(L2_WAYS), .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_address(in_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_full(q_full), .clearing(clearing),
    .push(push), .push_req(push_req), .cfg_eff(cfg_eff)
  );

  tlec_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req),
    .pop(pop), .head(head), .full(q_full), .empty(q_empty)
  );

  tlec_back #(
    .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_eff(cfg_eff), .head(head), .empty(q_empty),
    .pop(pop), .clearing(clearing), .out_valid(out_valid),
    .out_outcome(out_outcome), .out_victim_spilled(out_victim_spilled),
    .out_mem_read_total(out_mem_read_total),
    .out_mem_write_total(out_mem_write_total),
    .out_l1_hit_total(out_l1_hit_total), .out_l1_miss_total(out_l1_miss_total),
    .out_l2_hit_total(out_l2_hit_total)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the two-level exclusive cache model.
`timescale 1ns / 1ps
module tb_top;

  localparam int P1_SETS = tlec_pkg::DEF_L1_SETS;
  localparam int P1_WAYS = tlec_pkg::DEF_L1_WAYS;
  localparam int P2_SETS = tlec_pkg::DEF_L2_SETS;
  localparam int P2_WAYS = tlec_pkg::DEF_L2_WAYS;
  localparam int AW = tlec_pkg::ADDR_W;
  localparam int CW = tlec_pkg::CNT_W;
  localparam int SW = tlec_pkg::STAMP_W;
  localparam int IW = tlec_pkg::REG_IDX_W;
  localparam int DW = tlec_pkg::REG_DATA_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [1:0]    outcome;
    logic          spilled;
    logic [CW-1:0] rd_total;
    logic [CW-1:0] wr_total;
    logic [CW-1:0] l1h_total;
    logic [CW-1:0] l1m_total;
    logic [CW-1:0] l2h_total;
  } access_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [AW-1:0] in_address = '0;
  logic out_valid;
  logic [1:0] out_outcome;
  logic out_victim_spilled;
  logic [CW-1:0] out_mem_read_total, out_mem_write_total;
  logic [CW-1:0] out_l1_hit_total, out_l1_miss_total, out_l2_hit_total;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  two_level_exclusive_cache_model i_dut (.*);

  always #6 clk = ~clk;

  // Shadow cache state and settings
  logic [2:0] sh_l1sb;
  logic [2:0] sh_l1w;
  logic [3:0] sh_l2sb, sh_l2w, sh_bb;
  logic sh_l1p, sh_l2p;
  logic l1_v[P1_SETS*P1_WAYS];
  logic [AW-1:0] l1_a[P1_SETS*P1_WAYS];
  logic [SW-1:0] l1_f[P1_SETS*P1_WAYS], l1_u[P1_SETS*P1_WAYS];
  logic l2_v[P2_SETS*P2_WAYS];
  logic [AW-1:0] l2_a[P2_SETS*P2_WAYS];
  logic [SW-1:0] l2_f[P2_SETS*P2_WAYS];
  logic [SW-1:0] stamp;
  logic [CW-1:0] n_rd, n_wr, n_l1h, n_l1m, n_l2h;

  access_res_t pending_res[$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 0;
  logic [AW-1:0] pool_base;

  function automatic int fit_bits(int want, int sets);
    int b;
    b = 0;
    while (b < want && b < 31 && (2 << b) <= sets) b++;
    return b;
  endfunction

  function automatic int fit_ways(int want, int cap);
    if (want < 1) return 1;
    if (want > cap) return cap;
    return want;
  endfunction

  function automatic logic [CW-1:0] sat1(logic [CW-1:0] v);
    return (v == '1) ? v : v + CW'(1);
  endfunction

  function automatic logic [SW-1:0] tick();
    stamp = stamp + SW'(1);
    return stamp;
  endfunction

  function automatic logic [AW-1:0] rand_addr();
    return AW'({$urandom(), $urandom()});
  endfunction

  task automatic shadow_reset();
    sh_l1sb = 3'd6; sh_l1w = 3'd4; sh_l2sb = 4'd8; sh_l2w = 4'd8; sh_bb = 4'd6;
    sh_l1p = 1'b0; sh_l2p = 1'b0;
    foreach (l1_v[i]) begin
      l1_v[i] = 0; l1_a[i] = '0; l1_f[i] = '0; l1_u[i] = '0;
    end
    foreach (l2_v[i]) begin
      l2_v[i] = 0; l2_a[i] = '0; l2_f[i] = '0;
    end
    stamp = '0;
    n_rd = '0; n_wr = '0; n_l1h = '0; n_l1m = '0; n_l2h = '0;
  endtask

  // Place a line into its L2 set, evicting the oldest fill if full
  task automatic l2_insert(logic [AW-1:0] a);
    int set, ways, best, i;
    logic [SW-1:0] bs;
    set = int'((a >> sh_bb) & ((48'd1 << fit_bits(sh_l2sb, P2_SETS)) - 48'd1));
    ways = fit_ways(sh_l2w, P2_WAYS);
    best = -1;
    for (int w = 0; w < ways; w++)
      if (best < 0 && !l2_v[set*P2_WAYS+w]) best = w;
    if (best < 0) begin
      best = 0;
      bs = l2_f[set*P2_WAYS];
      for (int w = 1; w < ways; w++)
        if (l2_f[set*P2_WAYS+w] < bs) begin
          bs = l2_f[set*P2_WAYS+w];
          best = w;
        end
    end
    i = set*P2_WAYS + best;
    l2_v[i] = 1; l2_a[i] = a; l2_f[i] = tick();
  endtask

  task automatic fill_line(int i, logic [AW-1:0] a);
    logic [SW-1:0] s;
    s = tick();
    l1_v[i] = 1; l1_a[i] = a; l1_f[i] = s; l1_u[i] = s;
  endtask

  // Compute the result of one access and advance the shadow state
  task automatic predict_access(logic op, logic [AW-1:0] a, output access_res_t r);
    int s1, s2, sh1, sh2, w1, w2, hit, vw, vi;
    bit full;
    logic [SW-1:0] bs, st;
    logic [AW-1:0] va;
    s1 = int'((a >> sh_bb) & ((48'd1 << fit_bits(sh_l1sb, P1_SETS)) - 48'd1));
    s2 = int'((a >> sh_bb) & ((48'd1 << fit_bits(sh_l2sb, P2_SETS)) - 48'd1));
    sh1 = sh_bb + fit_bits(sh_l1sb, P1_SETS);
    sh2 = sh_bb + fit_bits(sh_l2sb, P2_SETS);
    w1 = fit_ways(sh_l1w, P1_WAYS);
    w2 = fit_ways(sh_l2w, P2_WAYS);
    r = '0;
    r.outcome = tlec_pkg::OUT_MISS;
    if (op) n_wr = sat1(n_wr);
    hit = -1;
    for (int w = 0; w < w1; w++)
      if (hit < 0 && l1_v[s1*P1_WAYS+w] && (l1_a[s1*P1_WAYS+w] >> sh1) == (a >> sh1))
        hit = s1*P1_WAYS + w;
    if (hit >= 0) begin
      l1_u[hit] = tick();
      n_l1h = sat1(n_l1h);
      r.outcome = tlec_pkg::OUT_L1_HIT;
    end else begin
      n_l1m = sat1(n_l1m);
      for (int w = 0; w < w2; w++)
        if (hit < 0 && l2_v[s2*P2_WAYS+w] && (l2_a[s2*P2_WAYS+w] >> sh2) == (a >> sh2))
          hit = s2*P2_WAYS + w;
      // choose the L1 way to fill
      vw = -1;
      for (int w = 0; w < w1; w++)
        if (vw < 0 && !l1_v[s1*P1_WAYS+w]) vw = w;
      full = (vw < 0);
      if (full) begin
        vw = 0;
        bs = sh_l1p ? l1_u[s1*P1_WAYS] : l1_f[s1*P1_WAYS];
        for (int w = 1; w < w1; w++) begin
          st = sh_l1p ? l1_u[s1*P1_WAYS+w] : l1_f[s1*P1_WAYS+w];
          if (st < bs) begin
            bs = st;
            vw = w;
          end
        end
      end
      vi = s1*P1_WAYS + vw;
      va = l1_a[vi];
      if (hit >= 0) begin
        n_l2h = sat1(n_l2h);
        r.outcome = tlec_pkg::OUT_L2_HIT;
        if (full) begin
          l2_v[hit] = 0;
          void'(tick());
          l2_insert(va);
          r.spilled = 1;
          fill_line(vi, a);
        end else begin
          fill_line(vi, a);
          l2_v[hit] = 0;
          void'(tick());
        end
      end else begin
        n_rd = sat1(n_rd);
        if (full) begin
          l2_insert(va);
          r.spilled = 1;
        end
        fill_line(vi, a);
      end
    end
    r.rd_total = n_rd; r.wr_total = n_wr; r.l1h_total = n_l1h;
    r.l1m_total = n_l1m; r.l2h_total = n_l2h;
  endtask

  // Send one access transaction; start stays high across back-to-back sends
  task automatic send_access(logic op, logic [AW-1:0] a);
    int gap;
    access_res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_address <= a;
    do @(posedge clk); while (busy);
    predict_access(op, a, r);
    pending_res.push_back(r);
  endtask

  // Drop start and wait until every result has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_res.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tlec_pkg::REG_L1_SET_BITS: sh_l1sb = val[2:0];
      tlec_pkg::REG_L1_WAYS:     sh_l1w = val[2:0];
      tlec_pkg::REG_L2_SET_BITS: sh_l2sb = val;
      tlec_pkg::REG_L2_WAYS:     sh_l2w = val;
      tlec_pkg::REG_BLOCK_BITS:  sh_bb = val;
      tlec_pkg::REG_L1_POLICY:   sh_l1p = val[0];
      tlec_pkg::REG_L2_POLICY:   sh_l2p = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int l1sb, int l1w, int l2sb, int l2w, int bb, int p1, int p2);
    write_reg(tlec_pkg::REG_L1_SET_BITS, DW'(l1sb));
    write_reg(tlec_pkg::REG_L1_WAYS, DW'(l1w));
    write_reg(tlec_pkg::REG_L2_SET_BITS, DW'(l2sb));
    write_reg(tlec_pkg::REG_L2_WAYS, DW'(l2w));
    write_reg(tlec_pkg::REG_BLOCK_BITS, DW'(bb));
    write_reg(tlec_pkg::REG_L1_POLICY, DW'(p1));
    write_reg(tlec_pkg::REG_L2_POLICY, DW'(p2));
  endtask

  // Mostly addresses from a small pool of lines so sets collide and hit
  function automatic logic [AW-1:0] pick_address();
    logic [AW-1:0] a;
    if ($urandom_range(0, 9) < 2) return rand_addr();
    a = pool_base ^ (AW'($urandom_range(0, 31)) << sh_bb);
    a = a ^ (rand_addr() & ((48'd1 << sh_bb) - 48'd1));
    return a;
  endfunction

  task automatic test_defaults();
    send_access(1'b0, '0);
    send_access(1'b0, '0);
    send_access(1'b1, '1);
    send_access(1'b1, '1);
    send_access(1'b0, 48'h0000_0000_003F);
    send_access(1'b1, 48'h8000_0000_0000);
    drain();
  endtask

  task automatic test_spill_paths();
    // one L1 line per set, four sets in L2
    set_geometry(0, 1, 2, 2, 4, 0, 0);
    send_access(1'b0, 48'h100);
    send_access(1'b0, 48'h200);
    send_access(1'b1, 48'h100);   // L2 hit with full L1 set, spills the other
    send_access(1'b0, 48'h200);
    drain();
    // a second way opens: L2 hit with a free L1 way
    write_reg(tlec_pkg::REG_L1_WAYS, 4'd2);
    send_access(1'b0, 48'h100);
    send_access(1'b0, 48'h300);
    drain();
    // LRU in L1: refresh the older line, then evict the other
    set_geometry(0, 2, 0, 1, 0, 1, 1);
    send_access(1'b0, 48'h10);
    send_access(1'b0, 48'h20);
    send_access(1'b0, 48'h10);
    send_access(1'b0, 48'h30);
    send_access(1'b0, 48'h20);
    send_access(1'b1, 48'h10);
    drain();
  endtask

  task automatic test_range_fit();
    // oversized set bits, zero and oversized ways, large block bits
    set_geometry(7, 0, 15, 0, 15, 0, 1);
    pool_base = rand_addr();
    repeat (12) send_access($urandom_range(0, 1), pick_address());
    drain();
    set_geometry(7, 7, 9, 15, 13, 1, 0);
    write_reg(3'd7, 4'hF);
    repeat (12) send_access($urandom_range(0, 1), pick_address());
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_geometry(6, 4, 8, 8, 0, 0, 0);
      else if (ph == 1) set_geometry(0, 1, 0, 1, 12, 1, 1);
      else set_geometry($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1),
                        $urandom_range(0, 1));
      pool_base = rand_addr();
      no_idle = (ph % 3 == 2);
      repeat (50) send_access($urandom_range(0, 1), pick_address());
      drain();
    end
    no_idle = 0;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    access_res_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_outcome, out_victim_spilled, out_mem_read_total, out_mem_write_total,
              out_l1_hit_total, out_l1_miss_total, out_l2_hit_total};
      if (pending_res.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches++;
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
          mismatches++;
        end
      end
    end
  end

  // Hold a hard limit on run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_spill_paths();
    test_range_fit();
    test_random();
    if (errors == 0 && pending_res.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tlec_pkg.sv
rtl/tlec_front.sv
rtl/tlec_queue.sv
rtl/tlec_back.sv
rtl/two_level_exclusive_cache_model.sv
tb/tb_top.sv
